>>> src/sinpi_pkg.sv
// shared types, widths and polynomial coefficients for the sin(pi*x) pipeline
package sinpi_pkg;

  localparam int WORK_BITS = 32;
  localparam int XM_W      = 31;
  localparam int T_W       = 29;
  localparam int ACC_W     = 36;
  localparam int MAG_W     = ACC_W - 1;
  localparam int N_STEPS   = 6;

  localparam logic [63:0] RND_HALF = 64'h0000_0000_8000_0000;

  localparam logic signed [ACC_W-1:0] SIN_INIT = 36'sd1982527;
  localparam logic signed [ACC_W-1:0] COS_INIT = 36'sd8190522;

  // horner coefficients in evaluation order, q.32
  localparam logic signed [ACC_W-1:0] SIN_STEP_COEF [N_STEPS] = '{
    -36'sd31654057, 36'sd352813826, -36'sd2573821554,
    36'sd10952871151, -36'sd22195157385, 36'sd13493037705
  };
  // last cosine step adds one
  localparam logic signed [ACC_W-1:0] COS_STEP_COEF [N_STEPS] = '{
    -36'sd110831553, 36'sd1010737020, -36'sd5734909917,
    36'sd17432035847, -36'sd21194814064, 36'sd4294967296
  };

  typedef struct packed {
    logic            flip;
    logic            is_cos;
    logic [XM_W-1:0] xm;
  } sp_side_t;

  typedef struct packed {
    sp_side_t                  side;
    logic [T_W-1:0]            t;
    logic signed [ACC_W-1:0]   acc;
  } sp_item_t;

endpackage

>>> src/sinpi_front.sv
// argument reduction: magnitude, fraction, fold and square
module sinpi_front import sinpi_pkg::*; #(
  parameter int IN_FRAC_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [47:0] x_value_i,
  output logic               valid_o,
  input  logic               ready_i,
  output sp_item_t           item_o
);

  localparam int SH = IN_FRAC_BITS - WORK_BITS;
  localparam logic [WORK_BITS:0] Q1  = 33'h0_4000_0000;
  localparam logic [WORK_BITS:0] Q2  = 33'h0_8000_0000;
  localparam logic [WORK_BITS:0] Q3  = 33'h0_C000_0000;
  localparam logic [WORK_BITS:0] ONE = 33'h1_0000_0000;

  logic [4:0] v_q;
  logic [4:0] en;

  assign en[4] = !v_q[4] || ready_i;
  assign en[3] = !v_q[3] || en[4];
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];

  assign ready_o = en[0];
  assign valid_o = v_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_q & ~en) | ({v_q[3:0], valid_i} & en);
    end
  end

  // stage 0: magnitude
  logic [47:0] mag_d, mag_q;
  logic        negx_q;
  assign mag_d = x_value_i[47] ? 48'(-x_value_i) : x_value_i;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mag_q  <= mag_d;
      negx_q <= x_value_i[47];
    end
  end

  // stage 1: fraction to q.32
  logic [WORK_BITS:0] a_d, a_q;
  logic               flip_q;

  if (SH > 0) begin : g_rnd
    logic [IN_FRAC_BITS:0] rsum;
    assign rsum = {1'b0, mag_q[IN_FRAC_BITS-1:0]} + ((IN_FRAC_BITS+1)'(1) << (SH - 1));
    assign a_d  = rsum[IN_FRAC_BITS:SH];
  end else begin : g_ext
    assign a_d = (WORK_BITS+1)'(mag_q[IN_FRAC_BITS-1:0]) << (-SH);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      a_q    <= a_d;
      flip_q <= negx_q ^ mag_q[IN_FRAC_BITS];
    end
  end

  // stage 2: branch select and fold
  sp_side_t side_d, side2_q;
  logic     cos_sel;
  assign cos_sel = (a_q >= Q1) && (a_q <= Q3);

  always_comb begin
    side_d.flip   = flip_q;
    side_d.is_cos = cos_sel;
    if (cos_sel) begin
      side_d.xm = (a_q >= Q2) ? XM_W'(a_q - Q2) : XM_W'(Q2 - a_q);
    end else begin
      side_d.xm = (a_q > Q3) ? XM_W'(ONE - a_q) : XM_W'(a_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      side2_q <= side_d;
    end
  end

  // stage 3: square
  logic [2*XM_W-1:0] sq_q;
  sp_side_t          side3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sq_q    <= (2*XM_W)'(side2_q.xm) * (2*XM_W)'(side2_q.xm);
      side3_q <= side2_q;
    end
  end

  // stage 4: round square to q.32, seed accumulator
  logic [2*XM_W:0] tsum;
  sp_item_t        item_d, item_q;
  assign tsum = {1'b0, sq_q} + (2*XM_W+1)'(RND_HALF);

  always_comb begin
    item_d.side = side3_q;
    item_d.t    = T_W'(tsum[2*XM_W:WORK_BITS]);
    item_d.acc  = side3_q.is_cos ? COS_INIT : SIN_INIT;
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

>>> src/sinpi_step.sv
// one horner step: multiply by t, round to q.32, add the next coefficient
module sinpi_step import sinpi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [ACC_W-1:0] sin_coef_i,
  input  logic signed [ACC_W-1:0] cos_coef_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  sp_item_t                item_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output sp_item_t                item_o
);

  localparam int PW = T_W + MAG_W;

  logic [1:0] v_q;
  logic [1:0] en;

  assign en[1]   = !v_q[1] || ready_i;
  assign en[0]   = !v_q[0] || en[1];
  assign ready_o = en[0];
  assign valid_o = v_q[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_q & ~en) | ({v_q[0], valid_i} & en);
    end
  end

  // multiply stage, on the magnitude of the accumulator
  logic [MAG_W-1:0] mag;
  logic [PW-1:0]    prod_q;
  logic             neg_q;
  logic [T_W-1:0]   t_q;
  sp_side_t         side_q;

  assign mag = item_i.acc[ACC_W-1] ? MAG_W'(-item_i.acc) : MAG_W'(item_i.acc);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q <= PW'(item_i.t) * PW'(mag);
      neg_q  <= item_i.acc[ACC_W-1];
      t_q    <= item_i.t;
      side_q <= item_i.side;
    end
  end

  // round half away from zero, then add coefficient
  logic [PW:0]             rsum;
  logic signed [ACC_W-1:0] r_s;
  logic signed [ACC_W-1:0] coef;
  sp_item_t                item_d, item_q;

  assign rsum = {1'b0, prod_q} + (PW+1)'(RND_HALF);
  assign r_s  = $signed(ACC_W'(rsum[PW:WORK_BITS]));
  assign coef = side_q.is_cos ? cos_coef_i : sin_coef_i;

  always_comb begin
    item_d.side = side_q;
    item_d.t    = t_q;
    item_d.acc  = neg_q ? (coef - r_s) : (coef + r_s);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

>>> src/sinpi_back.sv
// final sine multiply, sign, output rounding and saturation
module sinpi_back import sinpi_pkg::*; #(
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  sp_item_t           item_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [31:0] sine_result_o
);

  localparam int PW  = XM_W + MAG_W;
  localparam int SH  = WORK_BITS - OUT_FRAC_BITS;
  localparam int RW  = (OUT_FRAC_BITS > WORK_BITS) ? MAG_W + 1 - SH : MAG_W + 1;
  localparam logic [RW-1:0] LIM = (OUT_FRAC_BITS >= 31) ? RW'(32'h7FFF_FFFF)
                                                        : RW'(64'd1 << OUT_FRAC_BITS);

  logic [4:0] v_q;
  logic [4:0] en;

  assign en[4] = !v_q[4] || ready_i;
  assign en[3] = !v_q[3] || en[4];
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];

  assign ready_o = en[0];
  assign valid_o = v_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_q & ~en) | ({v_q[3:0], valid_i} & en);
    end
  end

  // stage 0: sine branch multiplies by the folded argument
  logic [MAG_W-1:0]        mag;
  logic [PW-1:0]           prod_q;
  logic                    accneg_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    flip0_q;
  logic                    is_cos_q;

  assign mag = item_i.acc[ACC_W-1] ? MAG_W'(-item_i.acc) : MAG_W'(item_i.acc);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q   <= PW'(item_i.side.xm) * PW'(mag);
      accneg_q <= item_i.acc[ACC_W-1];
      acc_q    <= item_i.acc;
      flip0_q  <= item_i.side.flip;
      is_cos_q <= item_i.side.is_cos;
    end
  end

  // stage 1: round product, cosine branch passes the accumulator
  logic [PW:0]             rsum;
  logic signed [ACC_W-1:0] r_s;
  logic signed [ACC_W-1:0] res_q;
  logic                    flip1_q;

  assign rsum = {1'b0, prod_q} + (PW+1)'(RND_HALF);
  assign r_s  = $signed(ACC_W'(rsum[PW:WORK_BITS]));

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      res_q   <= is_cos_q ? acc_q : (accneg_q ? -r_s : r_s);
      flip1_q <= flip0_q;
    end
  end

  // stage 2: sign and magnitude
  logic [MAG_W-1:0] rmag_q;
  logic             neg2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      rmag_q <= res_q[ACC_W-1] ? MAG_W'(-res_q) : MAG_W'(res_q);
      neg2_q <= flip1_q ^ res_q[ACC_W-1];
    end
  end

  // stage 3: convert to output format and saturate
  logic [RW-1:0] conv;
  logic [31:0]   omag_q;
  logic          neg3_q;

  if (SH > 0) begin : g_rnd
    logic [MAG_W:0] csum;
    assign csum = {1'b0, rmag_q} + ((MAG_W+1)'(1) << (SH - 1));
    assign conv = RW'(csum >> SH);
  end else begin : g_ext
    assign conv = RW'(rmag_q) << (-SH);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      omag_q <= (conv > LIM) ? 32'(LIM) : 32'(conv);
      neg3_q <= neg2_q;
    end
  end

  // stage 4: output register
  logic signed [31:0] out_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      out_q <= neg3_q ? $signed(-omag_q) : $signed(omag_q);
    end
  end

  assign sine_result_o = out_q;

endmodule

>>> src/sine_of_pi_times_x_top.sv
// sin(pi*x) evaluator, fully pipelined polynomial datapath
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  input    | in_valid_i/in_ready_o  | x_value_i     s48, q16.IN_FRAC_BITS
//  output   | out_valid_o/out_ready_i| sine_result_o s32, q.OUT_FRAC_BITS
//
// argument reduction and squaring come first, then the 6 horner steps, then
// the final multiply, rounding and saturation. one transfer per cycle is
// taken unless the output stalls; each stage has its own valid bit and moves
// whenever the stage after it is empty or moving, so bubbles close up on a stall.
// reset clears only the valid bits; data registers are not reset.
module sine_of_pi_times_x_top import sinpi_pkg::*; #(
  parameter int IN_FRAC_BITS  = 32,
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [47:0] x_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] sine_result_o
);

  sp_item_t item [N_STEPS+1];
  logic     vld  [N_STEPS+1];
  logic     rdy  [N_STEPS+1];

  sinpi_front #(
    .IN_FRAC_BITS(IN_FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .x_value_i(x_value_i),
    .valid_o  (vld[0]),
    .ready_i  (rdy[0]),
    .item_o   (item[0])
  );

  for (genvar g = 0; g < N_STEPS; g++) begin : g_step
    sinpi_step u_step (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .sin_coef_i(SIN_STEP_COEF[g]),
      .cos_coef_i(COS_STEP_COEF[g]),
      .valid_i   (vld[g]),
      .ready_o   (rdy[g]),
      .item_i    (item[g]),
      .valid_o   (vld[g+1]),
      .ready_i   (rdy[g+1]),
      .item_o    (item[g+1])
    );
  end

  sinpi_back #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (vld[N_STEPS]),
    .ready_o      (rdy[N_STEPS]),
    .item_i       (item[N_STEPS]),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .sine_result_o(sine_result_o)
  );

`ifndef SYNTHESIS
  // a sink that takes every transfer never backs up the input
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

  // result never exceeds plus or minus one (or the field limit)
  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (64'(sine_result_o) <= ((OUT_FRAC_BITS >= 31) ? 64'sh7FFF_FFFF
                                                    : (64'sd1 <<< OUT_FRAC_BITS))) &&
      (64'(sine_result_o) >= -((OUT_FRAC_BITS >= 31) ? 64'sh7FFF_FFFF
                                                     : (64'sd1 <<< OUT_FRAC_BITS))))
    else $error("result outside saturation range");
`endif

endmodule

>>> tb/sine_of_pi_times_x_top_tb.sv
// self-checking testbench for the sin(pi*x) evaluator with randomized handshakes
module sine_of_pi_times_x_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_FRAC   = 32;
  localparam int OUT_FRAC  = 30;
  localparam int WORK_FRAC = 32;
  localparam int RAND_ITEMS = 1800;
  localparam int DRAIN_CYCLES = 40;

  localparam longint Q_ONE = 64'sd1 << WORK_FRAC;
  localparam longint unsigned MASK48 = (64'd1 << 48) - 1;
  localparam longint unsigned SAT_LIM = (OUT_FRAC >= 31) ? 64'h7FFF_FFFF
                                                         : (64'd1 << OUT_FRAC);

  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN
  } ready_mode_e;

  typedef enum int {
    ARG_FULL_RANGE,
    ARG_SMALL,
    ARG_NEAR_EDGE,
    ARG_NEAR_LIMIT
  } arg_kind_e;

  typedef struct {
    logic [47:0]        x;
    logic signed [31:0] sine;
  } sine_expect_t;

  // q.32 coefficients, odd sine series and even cosine series (leading one added apart)
  longint sine_coef [7] = '{
    64'sd13493037705, -64'sd22195157385, 64'sd10952871151, -64'sd2573821554,
    64'sd352813826, -64'sd31654057, 64'sd1982527
  };
  longint cos_coef [6] = '{
    -64'sd21194814064, 64'sd17432035847, -64'sd5734909917, 64'sd1010737020,
    -64'sd110831553, 64'sd8190522
  };

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [47:0] x_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] sine_result_o;

  logic [47:0]  x_pending_q [$];
  sine_expect_t sine_expected_q [$];
  int           error_count = 0;

  int           burst_left = 1;
  int           gap_left = 0;
  ready_mode_e  ready_mode = READY_ALWAYS;
  int           ready_hold = 0;
  logic [15:0]  stall_pattern = 16'h00ff;

  sine_of_pi_times_x_top #(
    .IN_FRAC_BITS (IN_FRAC),
    .OUT_FRAC_BITS(OUT_FRAC)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .x_value_i    (x_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sine_result_o(sine_result_o)
  );

  function automatic longint unsigned round_half_up(longint unsigned v, int sh);
    if (sh <= 0) return v;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // product on magnitudes, rounded back to q.32, then signed
  function automatic longint q32_mul(longint p, longint q);
    longint unsigned up, uq, r;
    up = (p < 0) ? -p : p;
    uq = (q < 0) ? -q : q;
    r = round_half_up(up * uq, WORK_FRAC);
    return ((p < 0) != (q < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [31:0] sinpi_expected(logic [47:0] x);
    longint unsigned mag, frac, rmag;
    longint a, t, acc, res;
    logic odd, neg;
    int k;
    mag = x[47] ? (((64'd1 << 48) - {16'd0, x}) & MASK48) : {16'd0, x};
    odd = mag[IN_FRAC];
    frac = mag & ((64'd1 << IN_FRAC) - 1);
    if (IN_FRAC > WORK_FRAC) a = round_half_up(frac, IN_FRAC - WORK_FRAC);
    else a = frac << (WORK_FRAC - IN_FRAC);

    if (a >= Q_ONE / 4 && a <= 3 * (Q_ONE / 4)) begin
      // middle half: cosine series around one half
      t = q32_mul(Q_ONE / 2 - a, Q_ONE / 2 - a);
      acc = cos_coef[5];
      for (k = 4; k >= 0; k--) acc = cos_coef[k] + q32_mul(t, acc);
      res = Q_ONE + q32_mul(t, acc);
    end else begin
      if (a > 3 * (Q_ONE / 4)) a = Q_ONE - a;
      t = q32_mul(a, a);
      acc = sine_coef[6];
      for (k = 5; k >= 0; k--) acc = sine_coef[k] + q32_mul(t, acc);
      res = q32_mul(a, acc);
    end

    neg = x[47] ^ odd ^ (res < 0);
    rmag = (res < 0) ? -res : res;
    if (OUT_FRAC < WORK_FRAC) rmag = round_half_up(rmag, WORK_FRAC - OUT_FRAC);
    else rmag = rmag << (OUT_FRAC - WORK_FRAC);
    if (rmag > SAT_LIM) rmag = SAT_LIM;
    return neg ? -rmag[31:0] : rmag[31:0];
  endfunction

  task automatic add_arg(longint v);
    x_pending_q.push_back(v[47:0]);
  endtask

  function automatic longint random_arg(arg_kind_e kind);
    logic [63:0] r;
    longint v, edge_pos;
    r = {$urandom(), $urandom()};
    case (kind)
      ARG_FULL_RANGE: v = longint'(signed'(r[47:0]));
      ARG_SMALL: v = (longint'($urandom_range(0, 7)) << 32) + longint'(r[31:0]);
      ARG_NEAR_EDGE: begin
        edge_pos = longint'($urandom_range(0, 4)) << (WORK_FRAC - 2);
        v = (longint'($urandom_range(0, 15)) << 32) + edge_pos
            + longint'($urandom_range(0, 256)) - 128;
      end
      default: v = (64'sd1 << 47) - 1 - longint'(r[35:0]);
    endcase
    if (kind != ARG_FULL_RANGE && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // argument list: corner cases first, then random
  initial begin
    add_arg(0);
    add_arg(1);
    add_arg(-1);
    add_arg(64'sd1 << 32);
    add_arg(-(64'sd1 << 32));
    add_arg(64'sd3 << 32);
    add_arg(-(64'sd1 << 47));
    add_arg((64'sd1 << 47) - 1);
    add_arg((64'sd1 << 47) - (64'sd1 << 31));
    add_arg(64'sd1 << 30);
    add_arg((64'sd1 << 30) - 1);
    add_arg(64'sd3 << 30);
    add_arg((64'sd3 << 30) + 1);
    add_arg(64'sd1 << 31);
    add_arg(-(64'sd1 << 31));
    add_arg((64'sd1 << 31) + 1);
    add_arg((64'sd1 << 31) - 1);
    add_arg((64'sd3 << 31));
    add_arg(-(64'sd3 << 31));
    add_arg((64'sd1 << 32) - 1);
    add_arg(-((64'sd1 << 32) - 1));
    add_arg((64'sd5 << 32) + (64'sd1 << 29));
    for (int n = 0; n < RAND_ITEMS; n++)
      add_arg(random_arg(arg_kind_e'($urandom_range(0, 3))));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (x_pending_q.size() != 0 || in_valid_i || sine_expected_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS sine_of_pi_times_x_top");
    end else begin
      $display("FAIL sine_of_pi_times_x_top");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t timeout, %0d results outstanding", $time, sine_expected_q.size());
    $display("FAIL sine_of_pi_times_x_top");
    $finish;
  end

  // sender: bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        sine_expected_q.push_back('{x_value_i, sinpi_expected(x_value_i)});
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0 || x_pending_q.size() == 0) begin
          if (gap_left > 0) gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          x_value_i <= x_pending_q.pop_front();
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
            if ($urandom_range(0, 2) == 0) gap_left <= 0;
            else if ($urandom_range(0, 9) == 0) gap_left <= $urandom_range(10, 30);
            else gap_left <= $urandom_range(1, 4);
          end
        end
      end
    end
  end

  // receiver: switches between always ready, random stalls and a rotating pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (ready_hold == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 2));
        ready_hold = $urandom_range(20, 200);
        stall_pattern = 16'($urandom()) | 16'h0001;
      end
      ready_hold--;
      stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      case (ready_mode)
        READY_ALWAYS: out_ready_i <= 1'b1;
        READY_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
        default:      out_ready_i <= stall_pattern[0];
      endcase
    end
  end

  always @(posedge clk_i) begin
    sine_expect_t exp_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sine_expected_q.size() == 0) begin
        $display("%0t unexpected transfer: expected none, actual sine_result %0d",
                 $time, sine_result_o);
        error_count++;
      end else begin
        exp_item = sine_expected_q.pop_front();
        if (sine_result_o !== exp_item.sine) begin
          $display("%0t sine_result mismatch for x=%h: expected %0d, actual %0d",
                   $time, exp_item.x, exp_item.sine, sine_result_o);
          error_count++;
        end
      end
    end
  end

endmodule
